FILE: hw/rtl/lbss_pkg.sv
// Shared types, constants and the gamma duty lookup for the LED breathing step sequencer.
package lbss_pkg;

  // Field and register widths.
  localparam int unsigned PeriodW = 16;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Number of stored gamma entries.
  localparam int unsigned GammaEntries = 20;

  // Register reset values.
  localparam logic [PeriodW-1:0] PeriodReset    = 16'd32768;
  localparam logic               BounceReset    = 1'b1;
  localparam logic               StartDirReset  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriodCount   = 2'd0,
    CfgBounceMode    = 2'd1,
    CfgStartDir      = 2'd2,
    CfgUnused        = 2'd3
  } lbss_cfg_idx_e;

  // One result item.
  typedef struct packed {
    logic [DutyW-1:0] duty_value;
    logic [IdxW-1:0]  step_position;
  } lbss_result_t;

  // Gamma-corrected duty table in percent.
  localparam logic [DutyW-1:0] GammaDuty [GammaEntries] = '{
    7'd0,  7'd1,  7'd2,  7'd3,  7'd5,  7'd7,  7'd10, 7'd13, 7'd17, 7'd22,
    7'd27, 7'd33, 7'd39, 7'd46, 7'd53, 7'd61, 7'd70, 7'd79, 7'd89, 7'd100
  };

  // Indexes past the stored entries read the last entry.
  function automatic logic [DutyW-1:0] duty_at(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] clamped;
    clamped = (idx >= IdxW'(GammaEntries)) ? IdxW'(GammaEntries - 1) : idx;
    return GammaDuty[clamped];
  endfunction

endpackage

FILE: hw/rtl/lbss_step_core.sv
// Prescaler, step index and direction state with the next-step logic and duty lookup.
module lbss_step_core #(
  parameter int unsigned TABLE_LENGTH = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lbss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lbss_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                       fire_i,
  input  logic                       tick_i,
  output logic                       emit_o,
  output lbss_pkg::lbss_result_t     result_o
);
  import lbss_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_LENGTH - 1);

  logic [PeriodW-1:0] period_q;
  logic               bounce_q;
  logic [PeriodW-1:0] count_q, count_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               up_q, up_d;
  logic [IdxW-1:0]    nxt_idx;
  logic               in_range;
  logic               wrap_step;
  lbss_cfg_idx_e      cfg_sel;

  assign cfg_sel = lbss_cfg_idx_e'(cfg_index_i);

  // Next table index in the current direction; wrapping at an end never flips.
  always_comb begin
    if (up_q) begin
      in_range = (idx_q != LastIdx);
      nxt_idx  = in_range ? idx_q + 1'b1 : '0;
    end else begin
      in_range = (idx_q != '0);
      nxt_idx  = in_range ? idx_q - 1'b1 : LastIdx;
    end
  end

  // An accepted tick with the prescaler at or past the period steps the index.
  assign wrap_step = fire_i && tick_i && (count_q >= period_q);
  assign emit_o    = wrap_step;

  // Writing the start direction loads the direction state directly.
  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    up_d    = up_q;
    if (fire_i && tick_i) begin
      if (count_q < period_q) begin
        count_d = count_q + 1'b1;
      end else begin
        count_d = '0;
        idx_d   = nxt_idx;
        if (bounce_q && in_range && (nxt_idx == '0 || nxt_idx == LastIdx)) begin
          up_d = ~up_q;
        end
      end
    end
    if (cfg_we_i && cfg_sel == CfgStartDir) begin
      up_d = cfg_data_i[0];
    end
  end

  assign result_o.duty_value    = duty_at(nxt_idx);
  assign result_o.step_position = nxt_idx;

  // Configuration registers and sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      bounce_q <= BounceReset;
      count_q  <= '0;
      idx_q    <= '0;
      up_q     <= StartDirReset;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      up_q    <= up_d;
      if (cfg_we_i) begin
        unique case (cfg_sel)
          CfgPeriodCount: period_q <= cfg_data_i;
          CfgBounceMode:  bounce_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/lbss_out_reg.sv
// Result register that holds one item until the downstream side takes it.
module lbss_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  lbss_pkg::lbss_result_t data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output lbss_pkg::lbss_result_t data_o
);
  import lbss_pkg::*;

  logic         valid_q;
  lbss_result_t data_q;

  // Space is free when empty or when the held item leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/led_breathing_step_sequencer_unit.sv
// Top level of the LED breathing step sequencer with gamma-corrected duty output.
// A stepping tick item's result is registered and shows in the cycle after it is accepted.
// Throughput: one item per cycle while the downstream side takes results; the result register frees as it is read.
// Reset: asynchronous active low; prescaler and index clear, direction is up,
// registers return to period 32768, bounce on, start direction up.
module led_breathing_step_sequencer_unit #(
  parameter int unsigned TABLE_LENGTH = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         tick_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lbss_pkg::DutyW-1:0]   duty_value_o,
  output logic [lbss_pkg::IdxW-1:0]    step_position_o,
  input  logic                         cfg_we_i,
  input  logic [lbss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lbss_pkg::CfgW-1:0]    cfg_data_i
);
  import lbss_pkg::*;

  logic         in_fire;
  logic         step_emit;
  lbss_result_t step_result;
  lbss_result_t out_result;

  assign in_fire = in_valid_i && in_ready_o;

  // Sequencer state and next-step logic.
  lbss_step_core #(
    .TABLE_LENGTH(TABLE_LENGTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (in_fire),
    .tick_i     (tick_i),
    .emit_o     (step_emit),
    .result_o   (step_result)
  );

  // Result register.
  lbss_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step_emit),
    .data_i (step_result),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_result)
  );

  assign duty_value_o    = out_result.duty_value;
  assign step_position_o = out_result.step_position;

  // A stepping item always shows a result in the next cycle.
  a_step_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_emit |=> out_valid_o)
    else $error("stepping item produced no result");

  // An item without a step never leaves a stale result behind.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!step_emit && out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("result repeated after being taken");

  // Reported index stays inside the table.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (step_position_o <= IdxW'(TABLE_LENGTH - 1)))
    else $error("step position beyond table");

  // Duty output is a percentage.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_value_o <= DutyW'(100)))
    else $error("duty value above 100");

endmodule
